// ===== rtl/lst_pkg.sv =====
// Shared types and constants for the lazy segment tree range add / range sum block.
package lst_pkg;

    localparam int FIELD_IDX_W = 11;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 64;
    localparam int CNT_W       = 11;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;
    localparam logic             CMD_ADD   = 1'b0;
    localparam logic             CMD_QUERY = 1'b1;

    // register index lives in paddr[2]
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic [1:0] {
        UPD_COVER,
        UPD_LEFT,
        UPD_RIGHT
    } upd_sel_t;

    typedef struct packed {
        logic     clear_step;
        logic     start;
        logic     rd_node;
        logic     rd_tgt;
        logic     rd_left;
        logic     rd_right;
        logic     mul_lo;
        logic     mul_hi;
        logic     mul_sum;
        logic     wr_upd;
        logic     wr_pend_zero;
        logic     wr_fix;
        logic     fix_latch;
        logic     take_pend;
        logic     take_val;
        logic     acc_add;
        logic     push_left;
        logic     push_right;
        logic     pop;
        logic     emit;
        upd_sel_t upd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_add;
        logic add_bad;
        logic query_empty;
        logic covered;
        logic leaf;
        logic go_left;
        logic go_right;
        logic pend_zero;
        logic stack_empty;
        logic phase_right;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/lazy_segment_tree_range_add_sum.sv =====
// Lazy segment tree with range add and range sum, plus its APB register port.
// Elements 1..element_count live as a heap-indexed segment tree: node 1 covers
// the whole array, node k splits its span at the floor midpoint into 2k and
// 2k+1. Each node keeps a 64-bit wrapping sum and a pending add in two
// single-port-read RAMs of 4*MAX_ELEMENTS words. An add beat (command 0) adds
// add_value to every element of [range_low, range_high] and returns nothing;
// an add with an empty or out-of-bounds range is dropped. A query beat
// (command 1) clips the range to [1, element_count] and returns one beat with
// the sum, or 0 when nothing is left; both use element_count clamped to
// [1, MAX_ELEMENTS]. Commands run one at a time: a single controller walks
// the tree with an explicit stack, and every step goes through the one read
// and one write port of the node RAMs. A visited node is read and evaluated;
// a step down and back is a push, a return and a resume. A covered add adds
// value times span to the sum and value to the pending add; a pending add is
// pushed to both children the same way and cleared; an add refreshes each
// parent's sum from its children on the way up. A command over 1024 elements
// visits up to about 40 nodes. A query result sits in an output register, so
// the next beat is taken while it waits. After reset the block sweeps all
// 4*MAX_ELEMENTS words of both RAMs to zero, one word a cycle, before it
// takes a beat; register writes are taken during the sweep. element_count is
// at byte address 0; write it only while no command is in flight.
module lazy_segment_tree_range_add_sum #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lst_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [lst_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [lst_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    // command channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_command,
    input  logic [lst_pkg::FIELD_IDX_W-1:0]      s_range_low,
    input  logic [lst_pkg::FIELD_IDX_W-1:0]      s_range_high,
    input  logic signed [lst_pkg::VAL_W-1:0]     s_add_value,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lst_pkg::SUM_W-1:0]     m_range_sum
);

    logic [lst_pkg::CNT_W-1:0] count_reg;
    lst_pkg::dp_cmd_t          cmd;
    lst_pkg::dp_status_t       st;

    // register write: the index sits in paddr[2], byte lanes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= lst_pkg::CNT_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == lst_pkg::REG_ELEMENT_COUNT)) begin
            count_reg <= pwdata[lst_pkg::CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lst_pkg::REG_ELEMENT_COUNT)
                  ? {{(lst_pkg::APB_DATA_W - lst_pkg::CNT_W){1'b0}}, count_reg}
                  : '0;

    lst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    lst_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .s_command     (s_command),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .s_add_value   (s_add_value),
        .element_count (count_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_sum   (m_range_sum)
    );

endmodule

// ===== rtl/lst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lst_dp.sv =====
// Datapath: node memories, walk stack, multiplier, accumulator and result register.
module lst_dp #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lst_pkg::dp_cmd_t                     cmd,
    output lst_pkg::dp_status_t                  st,
    input  logic                                 s_command,
    input  logic [lst_pkg::FIELD_IDX_W-1:0]      s_range_low,
    input  logic [lst_pkg::FIELD_IDX_W-1:0]      s_range_high,
    input  logic signed [lst_pkg::VAL_W-1:0]     s_add_value,
    input  logic [lst_pkg::CNT_W-1:0]            element_count,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lst_pkg::SUM_W-1:0]     m_range_sum
);

    localparam int NODES  = 4 * MAX_ELEMENTS;
    localparam int NODE_W = $clog2(NODES);
    localparam int CLOG_N = $clog2(MAX_ELEMENTS + 1);
    localparam int IW     = (CLOG_N > lst_pkg::FIELD_IDX_W) ? CLOG_N : lst_pkg::FIELD_IDX_W;
    localparam int SDEPTH = $clog2(MAX_ELEMENTS) + 1;
    localparam int SP_W   = $clog2(SDEPTH + 1);
    localparam int SI_W   = $clog2(SDEPTH);
    localparam int SW     = lst_pkg::SUM_W;
    localparam int HW     = SW / 2;
    localparam int PW     = HW + IW;

    logic              is_add_reg;
    logic [IW-1:0]     x_reg, y_reg;
    logic [lst_pkg::VAL_W-1:0] val_reg;
    logic [NODE_W-1:0] cur_node_reg;
    logic [IW-1:0]     cur_lo_reg, cur_hi_reg;
    logic              phase_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [NODE_W-1:0] stk_node_reg [SDEPTH];
    logic [IW-1:0]     stk_lo_reg   [SDEPTH];
    logic [IW-1:0]     stk_hi_reg   [SDEPTH];
    logic              stk_ph_reg   [SDEPTH];
    logic [SW-1:0]     acc_reg, amt_reg, prod_reg, tmp_reg, m_sum_reg;
    logic [PW-1:0]     plo_reg, phi_reg;
    logic [NODE_W-1:0] clr_addr_reg;
    logic              m_valid_reg;

    logic [IW-1:0]     cnt_ext, n_act, x_eff, y_eff, mid, len;
    logic [IW:0]       lo_hi_sum;
    logic [NODE_W-1:0] left_node, right_node, tgt_node, raddr, waddr;
    logic [SI_W-1:0]   push_idx, top_idx;
    logic              re, we_sum, we_pend;
    logic [SW-1:0]     wd_sum, wd_pend, rd_sum, rd_pend;

    // clamp the element count to [1, MAX_ELEMENTS]
    assign cnt_ext = IW'(element_count);
    always_comb begin
        if (cnt_ext == '0) begin
            n_act = IW'(1);
        end else if (cnt_ext > IW'(MAX_ELEMENTS)) begin
            n_act = IW'(MAX_ELEMENTS);
        end else begin
            n_act = cnt_ext;
        end
    end

    assign x_eff      = (x_reg == '0) ? IW'(1) : x_reg;
    assign y_eff      = (y_reg > n_act) ? n_act : y_reg;
    assign lo_hi_sum  = {1'b0, cur_lo_reg} + {1'b0, cur_hi_reg};
    assign mid        = lo_hi_sum[IW:1];
    assign left_node  = {cur_node_reg[NODE_W-2:0], 1'b0};
    assign right_node = {cur_node_reg[NODE_W-2:0], 1'b1};
    assign push_idx   = SI_W'(sp_reg);
    assign top_idx    = SI_W'(sp_reg - SP_W'(1));

    always_comb begin
        case (cmd.upd_sel)
            lst_pkg::UPD_COVER: begin
                tgt_node = cur_node_reg;
                len      = cur_hi_reg - cur_lo_reg + IW'(1);
            end
            lst_pkg::UPD_LEFT: begin
                tgt_node = left_node;
                len      = mid - cur_lo_reg + IW'(1);
            end
            lst_pkg::UPD_RIGHT: begin
                tgt_node = right_node;
                len      = cur_hi_reg - mid;
            end
            default: begin
                tgt_node = cur_node_reg;
                len      = '0;
            end
        endcase
    end

    // read address
    assign re = cmd.rd_node | cmd.rd_tgt | cmd.rd_left | cmd.rd_right;
    always_comb begin
        if (cmd.rd_tgt) begin
            raddr = tgt_node;
        end else if (cmd.rd_left) begin
            raddr = left_node;
        end else if (cmd.rd_right) begin
            raddr = right_node;
        end else begin
            raddr = cur_node_reg;
        end
    end

    // write port
    always_comb begin
        we_sum  = 1'b0;
        we_pend = 1'b0;
        waddr   = cur_node_reg;
        wd_sum  = '0;
        wd_pend = '0;
        if (cmd.clear_step) begin
            we_sum  = 1'b1;
            we_pend = 1'b1;
            waddr   = clr_addr_reg;
        end else if (cmd.wr_upd) begin
            we_sum  = 1'b1;
            we_pend = 1'b1;
            waddr   = tgt_node;
            wd_sum  = rd_sum + prod_reg;
            wd_pend = rd_pend + amt_reg;
        end else if (cmd.wr_pend_zero) begin
            we_pend = 1'b1;
        end else if (cmd.wr_fix) begin
            we_sum = 1'b1;
            wd_sum = tmp_reg + rd_sum;
        end
    end

    lst_ram #(.WIDTH(SW), .DEPTH(NODES)) u_sum_ram (
        .aclk  (aclk),
        .we    (we_sum),
        .waddr (waddr),
        .wdata (wd_sum),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_sum)
    );

    lst_ram #(.WIDTH(SW), .DEPTH(NODES)) u_pend_ram (
        .aclk  (aclk),
        .we    (we_pend),
        .waddr (waddr),
        .wdata (wd_pend),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_pend)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            sp_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + NODE_W'(1);
            end
            if (cmd.start) begin
                sp_reg <= '0;
            end else if (cmd.push_left || cmd.push_right) begin
                sp_reg <= sp_reg + SP_W'(1);
            end else if (cmd.pop) begin
                sp_reg <= sp_reg - SP_W'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            is_add_reg   <= (s_command == lst_pkg::CMD_ADD);
            x_reg        <= IW'(s_range_low);
            y_reg        <= IW'(s_range_high);
            val_reg      <= s_add_value;
            cur_node_reg <= NODE_W'(1);
            cur_lo_reg   <= IW'(1);
            acc_reg      <= '0;
        end
        if (cmd.start) begin
            cur_hi_reg <= n_act;
        end else if (cmd.push_left || cmd.push_right) begin
            stk_node_reg[push_idx] <= cur_node_reg;
            stk_lo_reg[push_idx]   <= cur_lo_reg;
            stk_hi_reg[push_idx]   <= cur_hi_reg;
            stk_ph_reg[push_idx]   <= cmd.push_right;
            if (cmd.push_left) begin
                cur_node_reg <= left_node;
                cur_hi_reg   <= mid;
            end else begin
                cur_node_reg <= right_node;
                cur_lo_reg   <= mid + IW'(1);
            end
        end else if (cmd.pop) begin
            cur_node_reg <= stk_node_reg[top_idx];
            cur_lo_reg   <= stk_lo_reg[top_idx];
            cur_hi_reg   <= stk_hi_reg[top_idx];
            phase_reg    <= stk_ph_reg[top_idx];
        end
        if (cmd.take_val) begin
            amt_reg <= {{(SW - lst_pkg::VAL_W){val_reg[lst_pkg::VAL_W-1]}}, val_reg};
        end else if (cmd.take_pend) begin
            amt_reg <= rd_pend;
        end
        if (cmd.mul_lo) begin
            plo_reg <= amt_reg[HW-1:0] * PW'(len);
        end
        if (cmd.mul_hi) begin
            phi_reg <= amt_reg[SW-1:HW] * PW'(len);
        end
        if (cmd.mul_sum) begin
            prod_reg <= SW'(plo_reg) + {phi_reg[HW-1:0], {HW{1'b0}}};
        end
        if (cmd.fix_latch) begin
            tmp_reg <= rd_sum;
        end
        if (cmd.acc_add) begin
            acc_reg <= acc_reg + rd_sum;
        end
        if (cmd.emit) begin
            m_sum_reg <= acc_reg;
        end
    end

    assign st.clear_done  = (clr_addr_reg == NODE_W'(NODES - 1));
    assign st.is_add      = is_add_reg;
    assign st.add_bad     = (x_reg > y_reg) || (x_reg == '0) || (y_reg > n_act);
    assign st.query_empty = (x_eff > y_eff);
    assign st.covered     = (x_eff <= cur_lo_reg) && (cur_hi_reg <= y_eff);
    assign st.leaf        = (cur_lo_reg >= cur_hi_reg);
    assign st.go_left     = (mid >= x_eff);
    assign st.go_right    = (mid < y_eff);
    assign st.pend_zero   = (rd_pend == '0);
    assign st.stack_empty = (sp_reg == '0);
    assign st.phase_right = phase_reg;
    assign st.out_busy    = m_valid_reg & ~m_ready;

    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_sum_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_left || cmd.push_right) |-> (sp_reg < SP_W'(SDEPTH)))
        else $error("walk stack overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (sp_reg != '0))
        else $error("walk stack underflow");

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before it was taken");

endmodule

// ===== rtl/lst_ctrl.sv =====
// Controller: sequences clearing, tree walk, lazy push-down and sum refresh.
module lst_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lst_pkg::dp_status_t st,
    output lst_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_VISIT, S_EVAL,
        S_U_MLO, S_U_MHI, S_U_SUM, S_U_WR, S_PD_CLR,
        S_DESCEND, S_RET, S_RESUME, S_FX_RL, S_FX_RR, S_FX_W, S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    lst_pkg::upd_sel_t kind_reg, kind_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        cmd         = '0;
        cmd.upd_sel = kind_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (st.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (st.is_add && st.add_bad) begin
                    state_next = S_IDLE;
                end else if (!st.is_add && st.query_empty) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_VISIT;
                end
            end
            S_VISIT: begin
                cmd.rd_node = 1'b1;
                state_next  = S_EVAL;
            end
            S_EVAL: begin
                if (st.covered) begin
                    if (st.is_add) begin
                        cmd.take_val = 1'b1;
                        kind_next    = lst_pkg::UPD_COVER;
                        state_next   = S_U_MLO;
                    end else begin
                        cmd.acc_add = 1'b1;
                        state_next  = S_RET;
                    end
                end else if (st.leaf) begin
                    state_next = S_RET;
                end else if (st.pend_zero) begin
                    state_next = S_DESCEND;
                end else begin
                    cmd.take_pend = 1'b1;
                    kind_next     = lst_pkg::UPD_LEFT;
                    state_next    = S_U_MLO;
                end
            end
            S_U_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_U_MHI;
            end
            S_U_MHI: begin
                cmd.mul_hi = 1'b1;
                cmd.rd_tgt = 1'b1;
                state_next = S_U_SUM;
            end
            S_U_SUM: begin
                cmd.mul_sum = 1'b1;
                state_next  = S_U_WR;
            end
            S_U_WR: begin
                cmd.wr_upd = 1'b1;
                case (kind_reg)
                    lst_pkg::UPD_COVER: state_next = S_RET;
                    lst_pkg::UPD_LEFT: begin
                        kind_next  = lst_pkg::UPD_RIGHT;
                        state_next = S_U_MLO;
                    end
                    lst_pkg::UPD_RIGHT: state_next = S_PD_CLR;
                    default: state_next = S_RET;
                endcase
            end
            S_PD_CLR: begin
                cmd.wr_pend_zero = 1'b1;
                state_next       = S_DESCEND;
            end
            S_DESCEND: begin
                if (st.go_left) begin
                    cmd.push_left = 1'b1;
                    state_next    = S_VISIT;
                end else if (st.go_right) begin
                    cmd.push_right = 1'b1;
                    state_next     = S_VISIT;
                end else begin
                    state_next = S_RET;
                end
            end
            S_RET: begin
                if (st.stack_empty) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = S_RESUME;
                end
            end
            S_RESUME: begin
                if (!st.phase_right && st.go_right) begin
                    cmd.push_right = 1'b1;
                    state_next     = S_VISIT;
                end else if (st.is_add) begin
                    state_next = S_FX_RL;
                end else begin
                    state_next = S_RET;
                end
            end
            S_FX_RL: begin
                cmd.rd_left = 1'b1;
                state_next  = S_FX_RR;
            end
            S_FX_RR: begin
                cmd.rd_right  = 1'b1;
                cmd.fix_latch = 1'b1;
                state_next    = S_FX_W;
            end
            S_FX_W: begin
                cmd.wr_fix = 1'b1;
                state_next = S_RET;
            end
            S_FINISH: begin
                if (st.is_add) begin
                    state_next = S_IDLE;
                end else if (!st.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            kind_reg  <= lst_pkg::UPD_COVER;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the lazy segment tree range add / range sum block.
module testbench;

    localparam int FIELD_IDX_W = lst_pkg::FIELD_IDX_W;
    localparam int VAL_W       = lst_pkg::VAL_W;
    localparam int SUM_W       = lst_pkg::SUM_W;
    localparam int CNT_W       = lst_pkg::CNT_W;
    localparam int APB_ADDR_W  = lst_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = lst_pkg::APB_DATA_W;
    localparam logic [CNT_W-1:0] CNT_RESET = lst_pkg::CNT_RESET;
    localparam logic CMD_ADD   = lst_pkg::CMD_ADD;
    localparam logic CMD_QUERY = lst_pkg::CMD_QUERY;
    localparam logic REG_ELEMENT_COUNT = lst_pkg::REG_ELEMENT_COUNT;

    localparam int NODES      = 4096;
    localparam int MAX_ELEM   = 1024;
    localparam int DRAIN_CYC  = 1500;
    localparam int CYCLE_CAP  = 5000000;
    localparam int HOLD_CYC   = 3000;
    localparam int N_DIRECTED = 22;
    localparam int N_PHASES   = 8;

    typedef struct packed {
        logic                   command;
        logic [FIELD_IDX_W-1:0] lo;
        logic [FIELD_IDX_W-1:0] hi;
        logic [VAL_W-1:0]       value;
        logic                   typed;   // expected sum given in the row
        logic [SUM_W-1:0]       sum;
    } cmd_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_command;
    logic [FIELD_IDX_W-1:0] s_range_low;
    logic [FIELD_IDX_W-1:0] s_range_high;
    logic signed [VAL_W-1:0] s_add_value;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [SUM_W-1:0] m_range_sum;

    // predictor state: tree contents and the count register
    logic [SUM_W-1:0]       tree_sum  [NODES];
    logic [SUM_W-1:0]       tree_pend [NODES];
    logic [CNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]       sums_due [$];

    int  errors;
    int  sums_seen;
    int  cycles;
    bit  hold_fired;

    lazy_segment_tree_range_add_sum dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_range_low(s_range_low), .s_range_high(s_range_high),
        .s_add_value(s_add_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_range_sum(m_range_sum)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Count cycles and stop a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("lazy_segment_tree_range_add_sum: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor: heap-indexed tree, pending adds pushed one level down
    // on every descent. All arithmetic wraps at 64 bits.
    // ---------------------------------------------------------------
    function automatic logic [SUM_W-1:0] span_count();
        if (count_reg < 1) return SUM_W'(1);
        if (count_reg > MAX_ELEM) return SUM_W'(MAX_ELEM);
        return SUM_W'(count_reg);
    endfunction

    function automatic void push_pending(int k, logic [SUM_W-1:0] lo, logic [SUM_W-1:0] hi);
        logic [SUM_W-1:0] pend;
        logic [SUM_W-1:0] mid;
        pend = tree_pend[k];
        if (pend == 0 || 2 * k + 1 >= NODES) return;
        mid = (lo + hi) >> 1;
        tree_sum[2*k]    += pend * (mid - lo + 1);
        tree_pend[2*k]   += pend;
        tree_sum[2*k+1]  += pend * (hi - mid);
        tree_pend[2*k+1] += pend;
        tree_pend[k] = 0;
    endfunction

    function automatic void add_range(int k, logic [SUM_W-1:0] lo, logic [SUM_W-1:0] hi,
                                      logic [SUM_W-1:0] x, logic [SUM_W-1:0] y,
                                      logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] mid;
        if (k >= NODES) return;
        if (x <= lo && hi <= y) begin
            tree_sum[k]  += v * (hi - lo + 1);
            tree_pend[k] += v;
            return;
        end
        if (lo >= hi || 2 * k + 1 >= NODES) return;
        push_pending(k, lo, hi);
        mid = (lo + hi) >> 1;
        if (mid >= x) add_range(2 * k, lo, mid, x, y, v);
        if (mid < y) add_range(2 * k + 1, mid + 1, hi, x, y, v);
        tree_sum[k] = tree_sum[2*k] + tree_sum[2*k+1];
    endfunction

    function automatic logic [SUM_W-1:0] sum_range(int k, logic [SUM_W-1:0] lo,
                                                   logic [SUM_W-1:0] hi,
                                                   logic [SUM_W-1:0] x, logic [SUM_W-1:0] y);
        logic [SUM_W-1:0] mid;
        logic [SUM_W-1:0] acc;
        acc = 0;
        if (k >= NODES) return 0;
        if (x <= lo && hi <= y) return tree_sum[k];
        if (lo >= hi || 2 * k + 1 >= NODES) return 0;
        push_pending(k, lo, hi);
        mid = (lo + hi) >> 1;
        if (mid >= x) acc += sum_range(2 * k, lo, mid, x, y);
        if (mid < y) acc += sum_range(2 * k + 1, mid + 1, hi, x, y);
        return acc;
    endfunction

    // Apply one accepted beat; return 1 and the sum when it yields a result.
    function automatic bit apply_command(cmd_row_t c, output logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] n;
        logic [SUM_W-1:0] x;
        logic [SUM_W-1:0] y;
        n = span_count();
        x = SUM_W'(c.lo);
        y = SUM_W'(c.hi);
        sum = 0;
        if (c.command == CMD_ADD) begin
            if (x > y || x < 1 || y > n) return 0;
            add_range(1, 1, n, x, y, {{(SUM_W-VAL_W){c.value[VAL_W-1]}}, c.value});
            return 0;
        end
        if (x < 1) x = 1;
        if (y > n) y = n;
        if (x <= y) sum = sum_range(1, 1, n, x, y);
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic cmd_row_t random_command();
        cmd_row_t c;
        int n;
        n = int'(span_count());
        c = '0;
        c.command = ($urandom_range(0, 9) < 4) ? CMD_QUERY : CMD_ADD;
        case ($urandom_range(0, 9))
            0: begin
                // noise: any 11-bit bounds
                c.lo = FIELD_IDX_W'($urandom);
                c.hi = FIELD_IDX_W'($urandom);
            end
            1: begin
                c.lo = FIELD_IDX_W'($urandom_range(1, n));
                c.hi = c.lo;
            end
            default: begin
                c.lo = FIELD_IDX_W'($urandom_range(1, n));
                c.hi = FIELD_IDX_W'($urandom_range(int'(c.lo), n));
            end
        endcase
        case ($urandom_range(0, 3))
            0: c.value = VAL_W'($urandom_range(0, 16)) - VAL_W'(8);
            1: c.value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: c.value = $urandom;
        endcase
        return c;
    endfunction

    task automatic drive_beat(cmd_row_t c);
        logic [SUM_W-1:0] sum;
        int gap;
        @(negedge aclk);
        s_valid      = 1'b1;
        s_command    = c.command;
        s_range_low  = c.lo;
        s_range_high = c.hi;
        s_add_value  = c.value;
        do @(posedge aclk); while (!s_ready);
        if (apply_command(c, sum)) sums_due.push_back(c.typed ? c.sum : sum);
        // hold valid high straight into the next beat when there is no gap
        gap = gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Register write: setup then access, taken at the access edge.
    task automatic write_count(logic [CNT_W-1:0] value);
        @(negedge aclk);
        s_valid = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_ELEMENT_COUNT, 2'b00};
        pwdata  = APB_DATA_W'(value);
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        count_reg = value;
    endtask

    // Let the block go idle: all sums back, then room for a dropped add.
    task automatic drain();
        while (sums_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off that
    // lets the output register fill and stall the command channel.
    // ---------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_fired && sums_seen >= 40) begin
                hold_fired = 1'b1;
                hold_left  = HOLD_CYC;
            end
            if (hold_left > 0) begin
                m_ready   = 1'b0;
                hold_left = hold_left - 1;
            end else if (gap_len() > 0) begin
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Check each result beat against the oldest expected sum.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sums_seen <= sums_seen + 1;
            if (sums_due.size() == 0) begin
                $error("range_sum: unexpected beat, actual %0d", m_range_sum);
                errors <= errors + 1;
            end else begin
                if (m_range_sum !== $signed(sums_due[0])) begin
                    $error("range_sum: expected %0d actual %0d",
                           $signed(sums_due[0]), m_range_sum);
                    errors <= errors + 1;
                end
                void'(sums_due.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        cmd_row_t directed [N_DIRECTED];
        logic [CNT_W-1:0] phase_count [N_PHASES];
        int phase_items [N_PHASES];

        // directed rows; typed sums only where they are obvious
        directed = '{
            '{CMD_QUERY, 11'd1,    11'd1024, 32'd0,         1'b1, 64'd0},
            '{CMD_ADD,   11'd1,    11'd1024, 32'd1,         1'b0, 64'd0},
            '{CMD_QUERY, 11'd1,    11'd1024, 32'd0,         1'b1, 64'd1024},
            '{CMD_ADD,   11'd1024, 11'd1024, 32'h7FFF_FFFF, 1'b0, 64'd0},
            '{CMD_ADD,   11'd1,    11'd1,    32'h8000_0000, 1'b0, 64'd0},
            '{CMD_ADD,   11'd1,    11'd1024, 32'hFFFF_FFFF, 1'b0, 64'd0},
            '{CMD_QUERY, 11'd1,    11'd1,    32'd0,         1'b0, 64'd0},
            '{CMD_QUERY, 11'd1024, 11'd1024, 32'd0,         1'b0, 64'd0},
            '{CMD_QUERY, 11'd3,    11'd777,  32'h1234_5678, 1'b0, 64'd0},
            // empty add and out-of-bounds adds are dropped
            '{CMD_ADD,   11'd9,    11'd8,    32'd55,        1'b0, 64'd0},
            '{CMD_ADD,   11'd0,    11'd5,    32'd55,        1'b0, 64'd0},
            '{CMD_ADD,   11'd5,    11'd1025, 32'd55,        1'b0, 64'd0},
            '{CMD_ADD,   11'd2047, 11'd2047, 32'd55,        1'b0, 64'd0},
            // empty query, clipped query, query with nothing left
            '{CMD_QUERY, 11'd9,    11'd8,    32'd0,         1'b1, 64'd0},
            '{CMD_QUERY, 11'd0,    11'd2047, 32'hFFFF_FFFF, 1'b0, 64'd0},
            '{CMD_QUERY, 11'd2047, 11'd2047, 32'd0,         1'b1, 64'd0},
            '{CMD_QUERY, 11'd1025, 11'd2000, 32'd0,         1'b1, 64'd0},
            '{CMD_QUERY, 11'd0,    11'd0,    32'd0,         1'b1, 64'd0},
            '{CMD_ADD,   11'd100,  11'd612,  32'h7FFF_FFFF, 1'b0, 64'd0},
            '{CMD_ADD,   11'd300,  11'd301,  32'h8000_0001, 1'b0, 64'd0},
            '{CMD_QUERY, 11'd99,   11'd613,  32'd0,         1'b0, 64'd0},
            '{CMD_QUERY, 11'd1,    11'd1024, 32'd0,         1'b0, 64'd0}
        };
        // count settings per phase: clamp at both ends, and changes that
        // keep the old tree contents under a new span
        phase_count = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd2, 11'd37, 11'd600, 11'd1024};
        phase_items = '{400, 100, 250, 100, 100, 150, 150, 200};

        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_command  = CMD_ADD;
        s_range_low  = '0;
        s_range_high = '0;
        s_add_value  = '0;
        count_reg  = CNT_RESET;
        for (int k = 0; k < NODES; k++) begin
            tree_sum[k]  = '0;
            tree_pend[k] = '0;
        end

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // write the reset value back once while the sweep runs
        write_count(CNT_RESET);
        for (int i = 0; i < N_DIRECTED; i++) drive_beat(directed[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            @(negedge aclk);
            s_valid = 1'b0;
            drain();
            write_count(phase_count[p]);
            for (int i = 0; i < phase_items[p]; i++) drive_beat(random_command());
        end

        @(negedge aclk);
        s_valid = 1'b0;
        drain();
        if (errors == 0) begin
            $display("lazy_segment_tree_range_add_sum: match");
        end else begin
            $display("lazy_segment_tree_range_add_sum: mismatch");
        end
        $finish;
    end

endmodule
